// ===== rtl/first_fit_run_allocator_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the run allocator.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_RUN_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_RUN_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ffra_pkg.sv =====
// ---------------------------------------------------------------------------
// ffra_pkg
// Types and constants of the first-fit run allocator.
// ---------------------------------------------------------------------------
package ffra_pkg;

  localparam int SlotCount  = 4096;
  localparam int GroupCount = 128;
  localparam int AddrW      = $clog2(SlotCount);
  localparam int GroupW     = 7;
  localparam int LenW       = 13;
  localparam int StartW     = 12;
  localparam int StatusW    = 2;

  typedef enum logic [StatusW-1:0] {
    STATUS_PLACED  = 2'd0,
    STATUS_NOROOM  = 2'd1,
    STATUS_CLEARED = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_FILL,
    ST_CLR_SCAN,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/first_fit_run_allocator_core.sv =====
// ---------------------------------------------------------------------------
// first_fit_run_allocator_core
// Slot table allocator: places a group on the lowest run of free slots, or
// frees every slot of a group, scanning the table one entry per cycle.
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  request | in_valid_i, in_stall_o, opcode_i,        | in
//          | group_id_i, run_length_i                 |
//  result  | out_valid_o, out_stall_i, status_o,      | out
//          | start_slot_o                             |
//
// Allocate: the request is accepted, then the table is scanned through the
// single table read port, then run_length fill writes go through the write port.
// Clear: the request is accepted and the table is scanned. Rejected requests
// answer in the cycle after acceptance. After reset a clearing pass writes
// every slot with in_stall_o high. One request is in the block at a time;
// in_stall_o stays high until its result has been taken.
// ---------------------------------------------------------------------------
module first_fit_run_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [ffra_pkg::GroupW-1:0] group_id_i,
  input  logic [ffra_pkg::LenW-1:0]   run_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ffra_pkg::StatusW-1:0] status_o,
  output logic [ffra_pkg::StartW-1:0] start_slot_o
);

  localparam int AW = ffra_pkg::AddrW;
  localparam int GW = ffra_pkg::GroupW;
  localparam int LW = ffra_pkg::LenW;

  logic [GW-1:0] slot_mem [ffra_pkg::SlotCount];

  ffra_pkg::state_e  state_q, state_d;
  logic [AW:0]       addr_q, addr_d;
  logic              rvld_q, rvld_d;
  logic [AW-1:0]     prev_q, prev_d;
  logic [LW-1:0]     run_q, run_d;
  logic [AW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     fill_end_q, fill_end_d;
  logic [GW-1:0]     grp_q, grp_d;
  logic [LW-1:0]     len_q, len_d;
  ffra_pkg::status_e status_q, status_d;
  logic [AW-1:0]     start_q, start_d;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [GW-1:0]     rdata_q;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [GW-1:0]     wr_data;

  logic              grp_bad;
  logic              len_bad;
  logic              scan_done;
  logic [AW-1:0]     run_first;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  assign grp_bad   = (group_id_i == '0) || (32'(group_id_i) >= ffra_pkg::GroupCount);
  assign len_bad   = (run_length_i == '0) || (32'(run_length_i) > ffra_pkg::SlotCount);
  assign scan_done = !rvld_q && (addr_q == (AW+1)'(ffra_pkg::SlotCount));
  assign run_first = prev_q - AW'(len_q - LW'(1));

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    rvld_d     = 1'b0;
    prev_d     = prev_q;
    run_d      = run_q;
    fill_d     = fill_q;
    fill_end_d = fill_end_q;
    grp_d      = grp_q;
    len_d      = len_q;
    status_d   = status_q;
    start_d    = start_q;
    rd_en      = 1'b0;
    rd_addr    = addr_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = addr_q[AW-1:0];
    wr_data    = '0;

    // Both scans issue one read per cycle; the registered read data in rdata_q
    // is matched against the address held in prev_q.
    if ((state_q == ffra_pkg::ST_ALLOC_SCAN || state_q == ffra_pkg::ST_CLR_SCAN) &&
        (addr_q != (AW+1)'(ffra_pkg::SlotCount))) begin
      rd_en  = 1'b1;
      addr_d = addr_q + (AW+1)'(1);
      rvld_d = 1'b1;
      prev_d = addr_q[AW-1:0];
    end

    case (state_q)
      ffra_pkg::ST_INIT: begin
        wr_en  = 1'b1;
        addr_d = addr_q + (AW+1)'(1);
        if (addr_q == (AW+1)'(ffra_pkg::SlotCount - 1)) begin
          addr_d  = '0;
          state_d = ffra_pkg::ST_IDLE;
        end
      end
      ffra_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          grp_d  = group_id_i;
          len_d  = run_length_i;
          addr_d = '0;
          run_d  = '0;
          start_d = '0;
          if (opcode_i == ffra_pkg::OP_ALLOC) begin
            if (grp_bad || len_bad) begin
              status_d = ffra_pkg::STATUS_NOROOM;
              state_d  = ffra_pkg::ST_RESP;
            end else begin
              state_d = ffra_pkg::ST_ALLOC_SCAN;
            end
          end else begin
            status_d = ffra_pkg::STATUS_CLEARED;
            state_d  = grp_bad ? ffra_pkg::ST_RESP : ffra_pkg::ST_CLR_SCAN;
          end
        end
      end
      ffra_pkg::ST_ALLOC_SCAN: begin
        if (rvld_q) begin
          if (rdata_q == '0) begin
            if (run_q + LW'(1) == len_q) begin
              fill_d     = run_first;
              start_d    = run_first;
              fill_end_d = prev_q;
              rvld_d     = 1'b0;
              state_d    = ffra_pkg::ST_FILL;
            end else begin
              run_d = run_q + LW'(1);
            end
          end else begin
            run_d = '0;
          end
        end else if (scan_done) begin
          status_d = ffra_pkg::STATUS_NOROOM;
          start_d  = '0;
          state_d  = ffra_pkg::ST_RESP;
        end
      end
      ffra_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_q;
        wr_data = grp_q;
        fill_d  = fill_q + AW'(1);
        if (fill_q == fill_end_q) begin
          status_d = ffra_pkg::STATUS_PLACED;
          state_d  = ffra_pkg::ST_RESP;
        end
      end
      ffra_pkg::ST_CLR_SCAN: begin
        if (rvld_q && rdata_q == grp_q) begin
          wr_en   = 1'b1;
          wr_addr = prev_q;
        end
        if (scan_done) begin
          status_d = ffra_pkg::STATUS_CLEARED;
          state_d  = ffra_pkg::ST_RESP;
        end
      end
      ffra_pkg::ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ffra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffra_pkg::ST_INIT;
      addr_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    run_q      <= run_d;
    fill_q     <= fill_d;
    fill_end_q <= fill_end_d;
    grp_q      <= grp_d;
    len_q      <= len_d;
    status_q   <= status_d;
    start_q    <= start_d;
  end

  assign in_stall_o   = (state_q != ffra_pkg::ST_IDLE);
  assign out_valid_o  = (state_q == ffra_pkg::ST_RESP);
  assign status_o     = status_q;
  assign start_slot_o = ffra_pkg::StartW'(start_q);

endmodule

// ===== rtl/ffra_checker.sv =====
// ---------------------------------------------------------------------------
// ffra_checker
// Port-level checks on the run allocator, bound to its top level.
// ---------------------------------------------------------------------------
`include "first_fit_run_allocator_core_macros.svh"

module ffra_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ffra_pkg::StatusW-1:0] status_o,
  input logic [ffra_pkg::StartW-1:0]  start_slot_o
);

  logic                                          res_waiting;
  logic                                          res_unplaced;
  logic                                          req_taken;
  logic [ffra_pkg::StatusW+ffra_pkg::StartW-1:0] res_payload;

  assign res_waiting  = out_valid_o && out_stall_i;
  assign res_unplaced = out_valid_o && (status_o != ffra_pkg::STATUS_PLACED);
  assign req_taken    = in_valid_i && !in_stall_o;
  assign res_payload  = {status_o, start_slot_o};

  // A stalled result holds its value.
  `FFRA_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, res_waiting, out_valid_o && $stable(res_payload))

  // Only a placed run carries a start slot.
  `FFRA_ASSERT_IMPL(a_start_zero, clk_i, rst_ni, res_unplaced, start_slot_o == '0)

  // An accepted request keeps the block busy in the following cycle.
  `FFRA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_taken, in_stall_o)

  // No new request is taken while a result is pending.
  `FFRA_ASSERT_IMPL(a_one_in_flight, clk_i, rst_ni, out_valid_o, in_stall_o)

endmodule

bind first_fit_run_allocator_core ffra_checker u_ffra_checker (.*);
